// ===== sv/cmfs_pkg.sv =====
package cmfs_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 10;
    localparam int PLEN_W   = 10;
    localparam int STATUS_W = 2;

    localparam logic [BYTE_W-1:0] START_TAG_RESET = 8'hDB;

    localparam int NONCE_A_FIRST = 2;
    localparam int NONCE_A_LAST  = 9;
    localparam int LEN_HIGH_POS  = 11;
    localparam int LEN_LOW_POS   = 12;
    localparam int NONCE_B_FIRST = 14;
    localparam int NONCE_B_LAST  = 17;
    localparam int NONCE_B_SHIFT = 6;
    localparam int CIPHER_START  = 18;
    localparam int LENGTH_BIAS   = 17;
    localparam int TAG_BYTES     = 12;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NONCE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CIPHER  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TAG     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TAG = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   byte_value;
        logic [KIND_W-1:0]   byte_kind;
        logic [POS_W-1:0]    field_position;
        logic [PLEN_W-1:0]   payload_length;
        logic [STATUS_W-1:0] status;
        logic                frame_last;
    } t_result;

endpackage

// ===== sv/cmfs_classify.sv =====
module cmfs_classify #(
    parameter int MAX_FRAME = 1024
) (
    input  logic [cmfs_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic                             i_frame_first,
    input  logic [cmfs_pkg::BYTE_W-1:0]      i_start_tag,
    input  logic [$clog2(MAX_FRAME+1)-1:0]   i_byte_count,
    input  logic [cmfs_pkg::BYTE_W-1:0]      i_length_high,
    input  logic [$clog2(MAX_FRAME)-1:0]     i_cipher_length,
    input  logic [cmfs_pkg::STATUS_W-1:0]    i_error_code,
    input  logic                             i_frame_open,
    input  logic                             i_length_seen,
    output logic [$clog2(MAX_FRAME+1)-1:0]   o_byte_count,
    output logic [cmfs_pkg::BYTE_W-1:0]      o_length_high,
    output logic [$clog2(MAX_FRAME)-1:0]     o_cipher_length,
    output logic [cmfs_pkg::STATUS_W-1:0]    o_error_code,
    output logic                             o_frame_open,
    output logic                             o_length_seen,
    output cmfs_pkg::t_result                o_result
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int LW = $clog2(MAX_FRAME);

    logic [CW-1:0]                  cnt;
    logic [cmfs_pkg::BYTE_W-1:0]    lh;
    logic [LW-1:0]                  clen;
    logic [cmfs_pkg::STATUS_W-1:0]  err;
    logic                           seen;
    logic [15:0]                    idx;
    logic [15:0]                    max16;
    logic [15:0]                    tstart;
    logic [15:0]                    len_raw;
    logic [15:0]                    pos16;
    logic [15:0]                    plen16;
    logic [cmfs_pkg::KIND_W-1:0]    kind;
    logic                           last;
    logic                           in_frame;

    // a new telegram starts from cleared state
    assign cnt  = i_frame_first ? '0 : i_byte_count;
    assign lh   = i_frame_first ? '0 : i_length_high;
    assign clen = i_frame_first ? '0 : i_cipher_length;
    assign err  = i_frame_first ? cmfs_pkg::STATUS_OK : i_error_code;
    assign seen = i_frame_first ? 1'b0 : i_length_seen;
    assign o_frame_open = i_frame_first | i_frame_open;

    assign idx     = 16'(cnt);
    assign max16   = 16'(MAX_FRAME);
    assign tstart  = 16'(cmfs_pkg::CIPHER_START) + 16'(clen);
    assign len_raw = {lh, i_rx_byte} - 16'(cmfs_pkg::LENGTH_BIAS);
    assign in_frame = o_frame_open && (err == cmfs_pkg::STATUS_OK) && (idx < max16);

    always_comb begin
        kind            = cmfs_pkg::KIND_IGNORED;
        pos16           = '0;
        last            = 1'b0;
        o_error_code    = err;
        o_length_high   = lh;
        o_cipher_length = clen;
        o_length_seen   = seen;
        if (in_frame) begin
            if (idx == 16'd0) begin
                kind = cmfs_pkg::KIND_HEADER;
                if (i_rx_byte != i_start_tag) begin
                    o_error_code = cmfs_pkg::STATUS_BAD_TAG;
                end
            end else if (idx >= 16'(cmfs_pkg::NONCE_A_FIRST)
                         && idx <= 16'(cmfs_pkg::NONCE_A_LAST)) begin
                kind  = cmfs_pkg::KIND_NONCE;
                pos16 = idx - 16'(cmfs_pkg::NONCE_A_FIRST);
            end else if (idx >= 16'(cmfs_pkg::NONCE_B_FIRST)
                         && idx <= 16'(cmfs_pkg::NONCE_B_LAST)) begin
                kind  = cmfs_pkg::KIND_NONCE;
                pos16 = idx - 16'(cmfs_pkg::NONCE_B_SHIFT);
            end else if (idx < 16'(cmfs_pkg::CIPHER_START)) begin
                kind = cmfs_pkg::KIND_HEADER;
                if (idx == 16'(cmfs_pkg::LEN_HIGH_POS)) begin
                    o_length_high = i_rx_byte;
                end else if (idx == 16'(cmfs_pkg::LEN_LOW_POS)) begin
                    if (len_raw >= max16) begin
                        o_error_code    = cmfs_pkg::STATUS_BAD_LEN;
                        o_cipher_length = '0;
                    end else begin
                        o_cipher_length = len_raw[LW-1:0];
                        o_length_seen   = 1'b1;
                    end
                end
            end else if (idx < tstart) begin
                kind  = cmfs_pkg::KIND_CIPHER;
                pos16 = idx - 16'(cmfs_pkg::CIPHER_START);
            end else if (idx < tstart + 16'(cmfs_pkg::TAG_BYTES)) begin
                kind  = cmfs_pkg::KIND_TAG;
                pos16 = idx - tstart;
                last  = (idx == tstart + 16'(cmfs_pkg::TAG_BYTES - 1));
            end
        end
    end

    // saturate at the buffer size
    assign o_byte_count = (idx < max16) ? cnt + CW'(1) : cnt;

    assign plen16 = 16'(o_cipher_length);

    always_comb begin
        o_result.byte_value     = i_rx_byte;
        o_result.byte_kind      = kind;
        o_result.field_position = pos16[cmfs_pkg::POS_W-1:0];
        o_result.payload_length =
            (o_frame_open && o_length_seen && o_error_code == cmfs_pkg::STATUS_OK)
            ? plen16[cmfs_pkg::PLEN_W-1:0] : '0;
        o_result.status         = o_frame_open ? o_error_code : cmfs_pkg::STATUS_OK;
        o_result.frame_last     = last;
    end

endmodule

// ===== sv/ciphered_meter_frame_splitter_unit.sv =====
// Ciphered meter frame splitter.
// Input channel: one telegram byte per word (i_rx_byte) with i_frame_first
// marking byte 0 of a telegram; a word is taken when i_in_valid is high and
// o_in_stall is low. Output channel: one labelled word per input word
// (byte value, kind, field position, ciphertext length, status, last-tag
// flag); taken when o_out_valid is high and i_out_stall is low.
// Configuration: i_cfg_wr_en writes the required start tag from
// i_cfg_wr_data; write only while the block is idle.
// A taken word passes an input register, the classifier and the result
// register before it is presented at the output. Throughput: one word per
// cycle while the receiver does not stall, set by the single classifier
// pass on the per-telegram counters.
// Reset clears both stages, all telegram state and loads start tag 0xDB.
// When the receiver stalls, the result register holds its word, the input
// register keeps one more word, then o_in_stall rises until the output
// moves again.
module ciphered_meter_frame_splitter_unit #(
    parameter int MAX_FRAME = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [cmfs_pkg::BYTE_W-1:0]     i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cmfs_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                            i_frame_first,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [cmfs_pkg::BYTE_W-1:0]     o_byte_value,
    output logic [cmfs_pkg::KIND_W-1:0]     o_byte_kind,
    output logic [cmfs_pkg::POS_W-1:0]      o_field_position,
    output logic [cmfs_pkg::PLEN_W-1:0]     o_payload_length,
    output logic [cmfs_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_frame_last
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int LW = $clog2(MAX_FRAME);

    logic [cmfs_pkg::BYTE_W-1:0]    r_start_tag;
    logic                           r_in_valid;
    logic [cmfs_pkg::BYTE_W-1:0]    r_rx_byte;
    logic                           r_frame_first;
    logic [CW-1:0]                  r_byte_count;
    logic [cmfs_pkg::BYTE_W-1:0]    r_length_high;
    logic [LW-1:0]                  r_cipher_length;
    logic [cmfs_pkg::STATUS_W-1:0]  r_error_code;
    logic                           r_frame_open;
    logic                           r_length_seen;
    logic                           r_out_valid;
    cmfs_pkg::t_result              r_result;

    logic [CW-1:0]                  n_byte_count;
    logic [cmfs_pkg::BYTE_W-1:0]    n_length_high;
    logic [LW-1:0]                  n_cipher_length;
    logic [cmfs_pkg::STATUS_W-1:0]  n_error_code;
    logic                           n_frame_open;
    logic                           n_length_seen;
    cmfs_pkg::t_result              n_result;

    logic advance;
    logic in_take;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    cmfs_classify #(
        .MAX_FRAME (MAX_FRAME)
    ) u_classify (
        .i_rx_byte       (r_rx_byte),
        .i_frame_first   (r_frame_first),
        .i_start_tag     (r_start_tag),
        .i_byte_count    (r_byte_count),
        .i_length_high   (r_length_high),
        .i_cipher_length (r_cipher_length),
        .i_error_code    (r_error_code),
        .i_frame_open    (r_frame_open),
        .i_length_seen   (r_length_seen),
        .o_byte_count    (n_byte_count),
        .o_length_high   (n_length_high),
        .o_cipher_length (n_cipher_length),
        .o_error_code    (n_error_code),
        .o_frame_open    (n_frame_open),
        .o_length_seen   (n_length_seen),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_tag <= cmfs_pkg::START_TAG_RESET;
        end else if (i_cfg_wr_en) begin
            r_start_tag <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rx_byte     <= i_rx_byte;
            r_frame_first <= i_frame_first;
        end
    end

    // telegram state advances with each classified word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_length_high   <= '0;
            r_cipher_length <= '0;
            r_error_code    <= cmfs_pkg::STATUS_OK;
            r_frame_open    <= 1'b0;
            r_length_seen   <= 1'b0;
        end else if (advance) begin
            r_byte_count    <= n_byte_count;
            r_length_high   <= n_length_high;
            r_cipher_length <= n_cipher_length;
            r_error_code    <= n_error_code;
            r_frame_open    <= n_frame_open;
            r_length_seen   <= n_length_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_value     = r_result.byte_value;
    assign o_byte_kind      = r_result.byte_kind;
    assign o_field_position = r_result.field_position;
    assign o_payload_length = r_result.payload_length;
    assign o_status         = r_result.status;
    assign o_frame_last     = r_result.frame_last;

    a_last_is_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |-> (o_byte_kind == cmfs_pkg::KIND_TAG))
        else $error("frame_last on a word that is not an auth tag byte");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_byte_kind == cmfs_pkg::KIND_HEADER
                         || o_byte_kind == cmfs_pkg::KIND_IGNORED))
        |-> (o_field_position == '0))
        else $error("header or ignored word carries a field position");

    a_err_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != cmfs_pkg::STATUS_OK) |-> (o_payload_length == '0))
        else $error("length reported alongside an error status");

    a_err_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_frame_first && r_error_code != cmfs_pkg::STATUS_OK)
        |=> (r_result.byte_kind == cmfs_pkg::KIND_IGNORED))
        else $error("word classified after a telegram error");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (32'(r_byte_count) <= MAX_FRAME))
        else $error("byte counter beyond buffer size");

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    localparam int MAX_FRAME  = 1024;
    localparam int IDLE_LIMIT = 3000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [cmfs_pkg::BYTE_W-1:0]   i_cfg_wr_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [cmfs_pkg::BYTE_W-1:0]   i_rx_byte = '0;
    logic                          i_frame_first = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [cmfs_pkg::BYTE_W-1:0]   o_byte_value;
    logic [cmfs_pkg::KIND_W-1:0]   o_byte_kind;
    logic [cmfs_pkg::POS_W-1:0]    o_field_position;
    logic [cmfs_pkg::PLEN_W-1:0]   o_payload_length;
    logic [cmfs_pkg::STATUS_W-1:0] o_status;
    logic                          o_frame_last;

    ciphered_meter_frame_splitter_unit #(.MAX_FRAME(MAX_FRAME)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_frame_first    (i_frame_first),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_byte_value     (o_byte_value),
        .o_byte_kind      (o_byte_kind),
        .o_field_position (o_field_position),
        .o_payload_length (o_payload_length),
        .o_status         (o_status),
        .o_frame_last     (o_frame_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Telegram tracking state, mirrors the block after reset
    logic [cmfs_pkg::BYTE_W-1:0]   tag_now   = cmfs_pkg::START_TAG_RESET;
    int unsigned                   pos_next  = 0;
    logic [7:0]                    len_hi    = '0;
    logic [15:0]                   clen_now  = '0;
    logic [cmfs_pkg::STATUS_W-1:0] err_now   = cmfs_pkg::STATUS_OK;
    bit                            in_frame  = 1'b0;
    bit                            len_valid = 1'b0;

    cmfs_pkg::t_result label_q[$];
    int unsigned labelled_count = 0;
    int          mismatch_count = 0;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          idle_cycles = 0;

    function automatic cmfs_pkg::t_result label_byte(
        input logic [cmfs_pkg::BYTE_W-1:0] b, input logic is_first);
        cmfs_pkg::t_result r;
        int unsigned       tag_from;
        int unsigned       pos;
        logic [15:0]       len_raw;
        r = '0;
        pos = 0;
        r.byte_value = b;
        r.byte_kind  = cmfs_pkg::KIND_IGNORED;
        if (is_first) begin
            pos_next  = 0;
            len_hi    = '0;
            clen_now  = '0;
            err_now   = cmfs_pkg::STATUS_OK;
            in_frame  = 1'b1;
            len_valid = 1'b0;
        end
        if (in_frame && err_now == cmfs_pkg::STATUS_OK && pos_next < MAX_FRAME) begin
            tag_from = cmfs_pkg::CIPHER_START + clen_now;
            if (pos_next == 0) begin
                r.byte_kind = cmfs_pkg::KIND_HEADER;
                if (b != tag_now)
                    err_now = cmfs_pkg::STATUS_BAD_TAG;
            end else if (pos_next >= cmfs_pkg::NONCE_A_FIRST
                         && pos_next <= cmfs_pkg::NONCE_A_LAST) begin
                r.byte_kind = cmfs_pkg::KIND_NONCE;
                pos = pos_next - cmfs_pkg::NONCE_A_FIRST;
            end else if (pos_next >= cmfs_pkg::NONCE_B_FIRST
                         && pos_next <= cmfs_pkg::NONCE_B_LAST) begin
                r.byte_kind = cmfs_pkg::KIND_NONCE;
                pos = pos_next - cmfs_pkg::NONCE_B_SHIFT;
            end else if (pos_next < cmfs_pkg::CIPHER_START) begin
                r.byte_kind = cmfs_pkg::KIND_HEADER;
                if (pos_next == cmfs_pkg::LEN_HIGH_POS) begin
                    len_hi = b;
                end else if (pos_next == cmfs_pkg::LEN_LOW_POS) begin
                    // length field minus the bias, wrapping at 16 bits
                    len_raw = {len_hi, b} - 16'(cmfs_pkg::LENGTH_BIAS);
                    if (len_raw >= MAX_FRAME) begin
                        err_now  = cmfs_pkg::STATUS_BAD_LEN;
                        clen_now = '0;
                    end else begin
                        clen_now  = len_raw;
                        len_valid = 1'b1;
                    end
                end
            end else if (pos_next < tag_from) begin
                r.byte_kind = cmfs_pkg::KIND_CIPHER;
                pos = pos_next - cmfs_pkg::CIPHER_START;
            end else if (pos_next < tag_from + cmfs_pkg::TAG_BYTES) begin
                r.byte_kind  = cmfs_pkg::KIND_TAG;
                pos = pos_next - tag_from;
                r.frame_last = (pos_next == tag_from + cmfs_pkg::TAG_BYTES - 1);
            end
        end
        if (pos_next < MAX_FRAME)
            pos_next++;
        r.field_position = cmfs_pkg::POS_W'(pos);
        r.payload_length = (in_frame && len_valid && err_now == cmfs_pkg::STATUS_OK) ?
                           clen_now[cmfs_pkg::PLEN_W-1:0] : '0;
        r.status = in_frame ? err_now : cmfs_pkg::STATUS_OK;
        return r;
    endfunction

    task automatic send_byte(input logic [cmfs_pkg::BYTE_W-1:0] b, input logic is_first);
        cmfs_pkg::t_result r;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_first <= is_first;
        do @(posedge i_clk); while (o_in_stall);
        r = label_byte(b, is_first);
        label_q.push_back(r);
        if (r.byte_kind != cmfs_pkg::KIND_IGNORED)
            labelled_count++;
    endtask

    // Send the first n bytes of a telegram with the given start byte and length field
    task automatic send_frame(input logic [7:0] tag, input logic [15:0] len_field,
                              input int unsigned n);
        logic [7:0] b;
        for (int unsigned k = 0; k < n; k++) begin
            if (k == 0)
                b = tag;
            else if (k == cmfs_pkg::LEN_HIGH_POS)
                b = len_field[15:8];
            else if (k == cmfs_pkg::LEN_LOW_POS)
                b = len_field[7:0];
            else
                b = 8'($urandom);
            send_byte(b, k == 0);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (label_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_start_tag(input logic [cmfs_pkg::BYTE_W-1:0] v);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        tag_now = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        cmfs_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (label_q.size() == 0) begin
                $error("unexpected word: byte_value %0d", o_byte_value);
                mismatch_count++;
            end else begin
                want = label_q.pop_front();
                check_field("byte_value", 16'(want.byte_value), 16'(o_byte_value));
                check_field("byte_kind", 16'(want.byte_kind), 16'(o_byte_kind));
                check_field("field_position", 16'(want.field_position),
                            16'(o_field_position));
                check_field("payload_length", 16'(want.payload_length),
                            16'(o_payload_length));
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("frame_last", 16'(want.frame_last), 16'(o_frame_last));
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_before_first();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(cmfs_pkg::START_TAG_RESET, 1'b0);
    endtask

    task automatic test_bad_tag();
        send_frame(8'h00, 16'h0000, 4);
        send_frame(8'hFF, 16'hFFFF, 3);
    endtask

    task automatic test_bad_length();
        // one past the largest length the buffer allows, then a wrap below the bias
        send_frame(tag_now, 16'(MAX_FRAME + cmfs_pkg::LENGTH_BIAS), 14);
        send_frame(tag_now, 16'h0000, 13);
    endtask

    task automatic test_random_traffic(input int unsigned n);
        int unsigned target;
        int unsigned sel;
        int unsigned clen;
        int unsigned full;
        target = labelled_count + n;
        while (labelled_count < target) begin
            sel  = $urandom_range(99);
            clen = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(40);
            full = cmfs_pkg::CIPHER_START + clen + cmfs_pkg::TAG_BYTES;
            if (sel < 70) begin
                send_frame(tag_now, 16'(clen + cmfs_pkg::LENGTH_BIAS),
                           full + $urandom_range(3));
            end else if (sel < 80) begin
                // cut short by the next telegram
                send_frame(tag_now, 16'(clen + cmfs_pkg::LENGTH_BIAS),
                           $urandom_range(1, full - 1));
            end else if (sel < 88) begin
                send_frame(tag_now, 16'($urandom), $urandom_range(12, 20));
            end else if (sel < 94) begin
                send_frame(8'($urandom), 16'(clen + cmfs_pkg::LENGTH_BIAS),
                           $urandom_range(1, 5));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
            end
        end
    endtask

    task automatic test_long_telegram();
        // tag straddles the buffer end: its upper half is dropped, the count saturates
        send_frame(tag_now, 16'(MAX_FRAME - cmfs_pkg::CIPHER_START
                                - cmfs_pkg::TAG_BYTES / 2 + cmfs_pkg::LENGTH_BIAS),
                   MAX_FRAME + 8);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_first();
        test_bad_tag();
        test_bad_length();
        test_random_traffic(125);

        write_start_tag(8'h00);
        gap_pct = 73;
        test_random_traffic(125);

        write_start_tag(8'hFF);
        gap_pct   = 0;
        stall_pct = 73;
        test_random_traffic(125);

        write_start_tag(8'($urandom));
        gap_pct   = 14;
        stall_pct = 14;
        test_random_traffic(125);

        write_start_tag(cmfs_pkg::START_TAG_RESET);
        gap_pct   = 0;
        stall_pct = 0;
        test_long_telegram();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && label_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
